@@ design/ewma_bias_corrected_top_assert.svh @@
// ---------------------------------------------------------------------------
// ewma_bias_corrected_top_assert.svh
// Assertion macros for the bias-corrected EWMA block. They sample on clk and
// are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef EWMA_BIAS_CORRECTED_TOP_ASSERT_SVH
`define EWMA_BIAS_CORRECTED_TOP_ASSERT_SVH

// cond must hold at every edge out of reset
`define EWMABC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define EWMABC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define EWMABC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ewmabc_pkg.sv @@
// ---------------------------------------------------------------------------
// ewmabc_pkg
// Types and constants shared by the bias-corrected EWMA block.
// ---------------------------------------------------------------------------
package ewmabc_pkg;

  localparam int DATA_W  = 32;
  localparam int ALPHA_W = 17;
  localparam int BIAS_W  = 33;                 // Q0.32 with room for one
  localparam int MUL_A_W = BIAS_W + 1;         // signed operand A
  localparam int MUL_B_W = ALPHA_W + 1;        // signed operand B
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int QUO_W   = DATA_W + 1;
  localparam int CNT_W   = $clog2(QUO_W);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);
  localparam logic [BIAS_W-1:0]  BIAS_ONE    = {1'b1, {(BIAS_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
  localparam logic [DATA_W-1:0]  DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]  DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(QUO_W - 1);

  typedef enum logic [1:0] {
    REG_ALPHA     = 2'd0,
    REG_BIAS_CORR = 2'd1
  } reg_index_t;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_CLEAR  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_M,
    ST_MUL_B,
    ST_BIAS,
    ST_DIV_SETUP,
    ST_DIV,
    ST_DONE
  } state_t;

  // Operands for the shared multiplier
  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

@@ design/ewmabc_in_if.sv @@
// ---------------------------------------------------------------------------
// ewmabc_in_if
// Request channel into the EWMA block: a sample or a clear.
// ---------------------------------------------------------------------------
interface ewmabc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [ewmabc_pkg::DATA_W-1:0]  sample;

  modport source (output valid, mode, sample, input ready);
  modport sink   (input valid, mode, sample, output ready);
endinterface

@@ design/ewmabc_out_if.sv @@
// ---------------------------------------------------------------------------
// ewmabc_out_if
// Result channel out of the EWMA block.
// ---------------------------------------------------------------------------
interface ewmabc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  valid_res;
  logic signed [ewmabc_pkg::DATA_W-1:0]  mean;
  logic signed [ewmabc_pkg::DATA_W-1:0]  corrected;
  logic                                  saturated;

  modport source (output valid, valid_res, mean, corrected, saturated, input ready);
  modport sink   (input valid, valid_res, mean, corrected, saturated, output ready);
endinterface

@@ design/ewmabc_mul.sv @@
// ---------------------------------------------------------------------------
// ewmabc_mul
// Shared signed multiplier with a registered product, one result per cycle.
// ---------------------------------------------------------------------------
module ewmabc_mul (
  input  logic                                       clk,
  input  ewmabc_pkg::mul_req_t                       req,
  output logic signed [ewmabc_pkg::PROD_W-1:0]       prod
);

  logic signed [ewmabc_pkg::PROD_W-1:0] prod_next;

  assign prod_next = ewmabc_pkg::PROD_W'(req.a) * ewmabc_pkg::PROD_W'(req.b);

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule

@@ design/ewma_bias_corrected_top.sv @@
// ---------------------------------------------------------------------------
// ewma_bias_corrected_top
// Bias-corrected exponential moving average over signed Q16.16 samples.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request: mode 0 blends sample into the running mean,
//   mode 1 clears mean and bias product. Every request yields one result on
//   out_ch: valid_res, the plain mean, the corrected mean and a clip flag.
//   cfg_we/cfg_index/cfg_data write alpha (index 0, Q0.16, 65536 is one) and
//   the correction enable (index 1); write them only while the block is idle.
// Sequence:
//   a sample request passes three times through the shared 34x18
//   multiplier, then a rounding step, a divider setup state, the radix-2
//   restoring divider building a 33-bit quotient, and a load of the output
//   register. With correction off, a zero denominator or an overflowing
//   quotient the divider is skipped; a clear goes straight to the load.
//   ready is high only when idle, in the cycle after the load, so the block
//   takes no new request until it is through with the last one.
// Reset and stall:
//   rst (synchronous) loads alpha 6554, correction off, mean 0, bias
//   product one. The result sits in an output register; the block may take
//   the next request while it waits, and holds its new result until out_ch
//   drains.
// ---------------------------------------------------------------------------
`include "ewma_bias_corrected_top_assert.svh"

module ewma_bias_corrected_top (
  input  logic                                clk,
  input  logic                                rst,
  ewmabc_in_if.sink                           in_ch,
  ewmabc_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [ewmabc_pkg::ALPHA_W-1:0]      cfg_data
);

  localparam int DW = ewmabc_pkg::DATA_W;
  localparam int AW = ewmabc_pkg::ALPHA_W;
  localparam int BW = ewmabc_pkg::BIAS_W;
  localparam int PW = ewmabc_pkg::PROD_W;
  localparam int QW = ewmabc_pkg::QUO_W;

  ewmabc_pkg::state_t state, state_next;

  // configuration
  logic [AW-1:0] alpha;
  logic          corr_en;

  // model state
  logic                 seen_sample;
  logic signed [DW-1:0] running_mean;
  logic [BW-1:0]        bias_product;

  // request and datapath
  logic signed [DW-1:0]  sample_r;
  logic signed [PW-1:0]  acc;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  blend_sum;
  logic signed [PW-1:0]  bias_sum;
  logic [BW-1:0]         denom;
  logic [BW-1:0]         denom_r;
  logic [DW-1:0]         mag;
  logic [2*DW-1:0]       num;
  logic [BW-1:0]         rem;
  logic [BW:0]           rem_sh;
  logic                  rem_ge;
  logic [QW-1:0]         low;
  logic [QW-1:0]         quo;
  logic [ewmabc_pkg::CNT_W-1:0] cnt;
  logic                  neg;
  logic                  use_plain;
  logic                  ovf;
  logic                  skip_div;

  logic [AW-1:0]         a_eff;
  logic [AW-1:0]         ia;
  ewmabc_pkg::mul_req_t  mul_req;

  // output register
  logic                  out_valid;
  logic                  out_valid_res;
  logic signed [DW-1:0]  out_mean;
  logic signed [DW-1:0]  out_corr;
  logic                  out_sat;
  logic                  out_load;
  logic [DW-1:0]         res_corr;
  logic                  res_sat;

  logic in_fire;

  // assertion terms
  logic clr_fire;
  logic clr_ok;
  logic empty_res;
  logic res_zero;
  logic sat_res;
  logic sat_ok;

  assign in_fire = in_ch.valid && in_ch.ready;

  // alpha of 0 acts as one LSB, anything above one acts as one
  always_comb begin
    if (alpha == '0) begin
      a_eff = AW'(1);
    end else if (alpha > ewmabc_pkg::ALPHA_ONE) begin
      a_eff = ewmabc_pkg::ALPHA_ONE;
    end else begin
      a_eff = alpha;
    end
  end
  assign ia = ewmabc_pkg::ALPHA_ONE - a_eff;

  ewmabc_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // t >>> 16 equals the model's round-half-up on both signs
  assign blend_sum = acc + prod + ewmabc_pkg::ROUND_HALF;
  assign bias_sum  = prod + ewmabc_pkg::ROUND_HALF;

  assign denom = ewmabc_pkg::BIAS_ONE - bias_product;
  assign mag   = running_mean[DW-1] ? (~running_mean + DW'(1)) : running_mean;
  assign num   = {mag, {DW{1'b0}}} + (2*DW)'(denom[BW-1:1]);
  assign skip_div = !seen_sample || !corr_en || (denom == '0);

  assign rem_sh = {rem, low[QW-1]};
  assign rem_ge = rem_sh >= {1'b0, denom_r};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ewmabc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = (in_ch.mode == ewmabc_pkg::MODE_CLEAR) ?
                       ewmabc_pkg::ST_DONE : ewmabc_pkg::ST_MUL_X;
        end
      end
      ewmabc_pkg::ST_MUL_X:     state_next = ewmabc_pkg::ST_MUL_M;
      ewmabc_pkg::ST_MUL_M:     state_next = ewmabc_pkg::ST_MUL_B;
      ewmabc_pkg::ST_MUL_B:     state_next = ewmabc_pkg::ST_BIAS;
      ewmabc_pkg::ST_BIAS:      state_next = ewmabc_pkg::ST_DIV_SETUP;
      ewmabc_pkg::ST_DIV_SETUP: begin
        if (skip_div || ({2'b00, num[2*DW-1:QW]} >= denom)) begin
          state_next = ewmabc_pkg::ST_DONE;
        end else begin
          state_next = ewmabc_pkg::ST_DIV;
        end
      end
      ewmabc_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = ewmabc_pkg::ST_DONE;
        end
      end
      ewmabc_pkg::ST_DONE: begin
        if (!out_valid || out_ch.ready) begin
          state_next = ewmabc_pkg::ST_IDLE;
        end
      end
      default: state_next = ewmabc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    mul_req     = '0;
    unique case (state)
      ewmabc_pkg::ST_IDLE: in_ch.ready = 1'b1;
      ewmabc_pkg::ST_MUL_X: begin
        mul_req.a = (ewmabc_pkg::MUL_A_W)'(sample_r);
        mul_req.b = (ewmabc_pkg::MUL_B_W)'(signed'({1'b0, a_eff}));
      end
      ewmabc_pkg::ST_MUL_M: begin
        mul_req.a = (ewmabc_pkg::MUL_A_W)'(running_mean);
        mul_req.b = (ewmabc_pkg::MUL_B_W)'(signed'({1'b0, ia}));
      end
      ewmabc_pkg::ST_MUL_B: begin
        mul_req.a = signed'({1'b0, bias_product});
        mul_req.b = (ewmabc_pkg::MUL_B_W)'(signed'({1'b0, ia}));
      end
      ewmabc_pkg::ST_DONE: out_load = !out_valid || out_ch.ready;
      default: ;
    endcase
  end

  // control state and model state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ewmabc_pkg::ST_IDLE;
      alpha           <= ewmabc_pkg::ALPHA_RESET;
      corr_en         <= 1'b0;
      seen_sample     <= 1'b0;
      running_mean    <= '0;
      bias_product    <= ewmabc_pkg::BIAS_ONE;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          ewmabc_pkg::REG_ALPHA:     alpha           <= cfg_data;
          ewmabc_pkg::REG_BIAS_CORR: corr_en         <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire && (in_ch.mode == ewmabc_pkg::MODE_CLEAR)) begin
        seen_sample  <= 1'b0;
        running_mean <= '0;
        bias_product <= ewmabc_pkg::BIAS_ONE;
      end
      if (state == ewmabc_pkg::ST_MUL_B) begin
        running_mean <= seen_sample ? blend_sum[DW+15:16] : sample_r;
        seen_sample  <= 1'b1;
      end
      if (state == ewmabc_pkg::ST_BIAS) begin
        bias_product <= bias_sum[BW+15:16];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r  <= in_ch.sample;
      use_plain <= 1'b1;
      ovf       <= 1'b0;
    end
    if (state == ewmabc_pkg::ST_MUL_M) begin
      acc <= prod;
    end
    if (state == ewmabc_pkg::ST_DIV_SETUP) begin
      use_plain <= skip_div;
      neg       <= running_mean[DW-1];
      denom_r   <= denom;
      rem       <= {2'b00, num[2*DW-1:QW]};
      low       <= num[QW-1:0];
      ovf       <= !skip_div && ({2'b00, num[2*DW-1:QW]} >= denom);
      cnt       <= ewmabc_pkg::DIV_LAST;
      quo       <= '0;
    end
    if (state == ewmabc_pkg::ST_DIV) begin
      rem <= rem_ge ? BW'(rem_sh - {1'b0, denom_r}) : rem_sh[BW-1:0];
      low <= {low[QW-2:0], 1'b0};
      quo <= {quo[QW-2:0], rem_ge};
      cnt <= cnt - 1'b1;
    end
  end

  // clip the quotient to the sample range
  always_comb begin
    res_corr = running_mean;
    res_sat  = 1'b0;
    if (!use_plain) begin
      if (ovf) begin
        res_sat  = 1'b1;
        res_corr = neg ? ewmabc_pkg::DATA_MIN : ewmabc_pkg::DATA_MAX;
      end else if (!neg) begin
        if (quo > {1'b0, ewmabc_pkg::DATA_MAX}) begin
          res_sat  = 1'b1;
          res_corr = ewmabc_pkg::DATA_MAX;
        end else begin
          res_corr = quo[DW-1:0];
        end
      end else begin
        if (quo > {1'b0, ewmabc_pkg::DATA_MIN}) begin
          res_sat  = 1'b1;
          res_corr = ewmabc_pkg::DATA_MIN;
        end else begin
          res_corr = ~quo[DW-1:0] + DW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_valid_res <= seen_sample;
      out_mean      <= running_mean;
      out_corr      <= res_corr;
      out_sat       <= res_sat;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.valid_res = out_valid_res;
  assign out_ch.mean      = out_mean;
  assign out_ch.corrected = out_corr;
  assign out_ch.saturated = out_sat;

  assign clr_fire  = in_fire && (in_ch.mode == ewmabc_pkg::MODE_CLEAR);
  assign clr_ok    = (state == ewmabc_pkg::ST_DONE) && !seen_sample && (running_mean == '0);
  assign empty_res = out_valid && !out_valid_res;
  assign res_zero  = (out_mean == '0) && (out_corr == '0) && !out_sat;
  assign sat_res   = out_valid && out_sat;
  assign sat_ok    = out_valid_res && corr_en;

  `EWMABC_ASSERT_ALWAYS(a_bias_le_one, bias_product <= ewmabc_pkg::BIAS_ONE, "bias above one")
  `EWMABC_ASSERT_NEXT(a_clear_to_done, clr_fire, clr_ok, "clear did not reset state")
  `EWMABC_ASSERT_IMPL(a_empty_result_zero, empty_res, res_zero, "empty result not zero")
  `EWMABC_ASSERT_IMPL(a_sat_needs_corr, sat_res, sat_ok, "clip flag without correction")

endmodule

@@ tb/ewma_bias_corrected_top_test.sv @@
// ---------------------------------------------------------------------------
// ewma_bias_corrected_top_test
// Self-checking bench for the bias-corrected EWMA block. A local model of the
// running mean, bias product and corrected quotient predicts every result.
// Directed requests cover field extremes, clears, saturation and alpha
// limits, then random phases run under varied alpha and correction settings
// with random stalls on both channels.
// ---------------------------------------------------------------------------
module ewma_bias_corrected_top_test;
  import ewmabc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 2000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned PRINT_LIMIT   = 100;
  // Indexes past the register file; writes there must be ignored
  localparam logic [1:0]  REG_SPARE_A   = 2'd2;
  localparam logic [1:0]  REG_SPARE_B   = 2'd3;

  typedef struct packed {
    logic                     valid_res;
    logic signed [DATA_W-1:0] mean;
    logic signed [DATA_W-1:0] corrected;
    logic                     saturated;
  } avg_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [ALPHA_W-1:0]   cfg_data;

  ewmabc_in_if  in_ch ();
  ewmabc_out_if out_ch ();

  ewma_bias_corrected_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block's registers and averaging state
  logic [ALPHA_W-1:0]   alpha_q;
  logic                 corr_on;
  logic                 have_sample;
  longint               avg_q;
  longint unsigned      bias_q;

  avg_result_t          pending_avgs[$];
  int unsigned          fail_count;
  int unsigned          results_seen;
  int unsigned          cycle_count;
  int unsigned          rx_wait;
  bit                   idle_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_error(input string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Advances the shadow state by one request and returns the expected result
  function automatic avg_result_t advance_average(input mode_t req_mode,
                                                  input logic signed [DATA_W-1:0] req_sample);
    avg_result_t     r;
    longint unsigned a;
    longint unsigned ia;
    longint unsigned d;
    longint unsigned mag;
    longint unsigned q;
    longint          w;
    logic            neg;
    r = '0;
    if (req_mode == MODE_CLEAR) begin
      have_sample = 1'b0;
      avg_q       = 0;
      bias_q      = BIAS_ONE;
    end else begin
      if (alpha_q == '0) a = 1;
      else if (alpha_q > ALPHA_ONE) a = ALPHA_ONE;
      else a = alpha_q;
      ia = ALPHA_ONE - a;
      if (!have_sample) begin
        avg_q       = longint'(req_sample);
        have_sample = 1'b1;
      end else begin
        w     = longint'(a) * longint'(req_sample) + longint'(ia) * avg_q;
        // floor((w + half) / 2^16): nearest, ties toward +inf
        avg_q = (w + 64'sd32768) >>> 16;
      end
      bias_q = (bias_q * ia + 64'd32768) >> 16;
    end

    if (have_sample) begin
      r.valid_res = 1'b1;
      r.mean      = avg_q[DATA_W-1:0];
      d           = BIAS_ONE - bias_q;
      if (!corr_on || d == 0) begin
        r.corrected = avg_q[DATA_W-1:0];
      end else begin
        neg = (avg_q < 0);
        mag = neg ? -avg_q : avg_q;
        // ties away from zero, applied to the magnitude
        q   = ((mag << 32) + (d >> 1)) / d;
        if (!neg) begin
          if (q > DATA_MAX) begin
            q           = DATA_MAX;
            r.saturated = 1'b1;
          end
        end else begin
          if (q > DATA_MIN) begin
            q           = DATA_MIN;
            r.saturated = 1'b1;
          end
          q = -q;
        end
        r.corrected = q[DATA_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic send_request(input mode_t req_mode,
                              input logic signed [DATA_W-1:0] req_sample);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    // valid stays high from the previous request unless a gap is drawn
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= req_mode;
    in_ch.sample <= req_sample;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_avgs.push_back(advance_average(req_mode, req_sample));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_avgs.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ALPHA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ALPHA:     alpha_q = value;
      REG_BIAS_CORR: corr_on = value[0];
      default: ;
    endcase
  endtask

  task automatic check_average();
    avg_result_t want;
    results_seen++;
    if (pending_avgs.size() == 0) begin
      report_error($sformatf("result %0d arrived with no request outstanding",
                             results_seen));
      return;
    end
    want = pending_avgs.pop_front();
    if (out_ch.valid_res !== want.valid_res)
      report_error($sformatf("result %0d valid_res: got %b, expected %b",
                             results_seen, out_ch.valid_res, want.valid_res));
    if (out_ch.mean !== want.mean)
      report_error($sformatf("result %0d mean: got %0d, expected %0d",
                             results_seen, out_ch.mean, want.mean));
    if (out_ch.corrected !== want.corrected)
      report_error($sformatf("result %0d corrected: got %0d, expected %0d",
                             results_seen, out_ch.corrected, want.corrected));
    if (out_ch.saturated !== want.saturated)
      report_error($sformatf("result %0d saturated: got %b, expected %b",
                             results_seen, out_ch.saturated, want.saturated));
  endtask

  // Result side: random hold-off after each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_average();
        rx_wait = idle_on ? $urandom_range(0, 8) : 0;
        out_ch.ready <= (rx_wait == 0);
      end else if (out_ch.ready !== 1'b1) begin
        if (rx_wait != 0) rx_wait--;
        if (rx_wait == 0) out_ch.ready <= 1'b1;
      end
    end
  end

  // Reset values, empty-state clear and field extremes with correction off
  task automatic test_defaults();
    send_request(MODE_CLEAR, '0);
    send_request(MODE_SAMPLE, DATA_MAX);
    send_request(MODE_SAMPLE, DATA_MIN);
    send_request(MODE_SAMPLE, 32'sh0001_2345);
    send_request(MODE_SAMPLE, -32'sd1);
  endtask

  // Smallest alpha keeps the denominator tiny, so large means clip both ways
  task automatic test_saturation();
    wait_for_results();
    write_reg(REG_ALPHA, ALPHA_W'(1));
    write_reg(REG_BIAS_CORR, ALPHA_W'(1));
    send_request(MODE_CLEAR, '0);
    send_request(MODE_SAMPLE, DATA_MAX);
    send_request(MODE_SAMPLE, DATA_MIN);
    send_request(MODE_CLEAR, '1);
    send_request(MODE_SAMPLE, DATA_MIN);
    send_request(MODE_CLEAR, '0);
    send_request(MODE_SAMPLE, 32'sd1);
    send_request(MODE_SAMPLE, -32'sd1);
  endtask

  // Zero alpha acts as the smallest step, anything past one acts as one
  task automatic test_alpha_limits();
    wait_for_results();
    write_reg(REG_ALPHA, '0);
    send_request(MODE_CLEAR, '0);
    send_request(MODE_SAMPLE, 32'sd5);
    send_request(MODE_SAMPLE, -32'sd5);
    wait_for_results();
    write_reg(REG_ALPHA, ALPHA_ONE);
    send_request(MODE_SAMPLE, DATA_MAX);
    send_request(MODE_SAMPLE, -32'sd1);
    wait_for_results();
    write_reg(REG_ALPHA, '1);
    send_request(MODE_SAMPLE, 32'sd3);
    send_request(MODE_SAMPLE, DATA_MIN);
    wait_for_results();
    // upper data bits set, only bit 0 counts
    write_reg(REG_BIAS_CORR, '1 ^ ALPHA_W'(1));
    send_request(MODE_SAMPLE, 32'sd7);
  endtask

  task automatic test_spare_index();
    wait_for_results();
    write_reg(REG_SPARE_A, '0);
    write_reg(REG_SPARE_B, '1);
    send_request(MODE_SAMPLE, 32'sd100);
    send_request(MODE_SAMPLE, -32'sd100);
  endtask

  task automatic test_random();
    int unsigned              per_phase;
    int unsigned              pick;
    logic signed [DATA_W-1:0] value;
    logic [ALPHA_W-1:0]       alpha_pick;
    logic                     corr_pick;
    per_phase = RANDOM_ITEMS / RANDOM_PHASES;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_results();
      case (p)
        0:       alpha_pick = ALPHA_W'(1);
        1:       alpha_pick = ALPHA_ONE;
        2:       alpha_pick = '0;
        3:       alpha_pick = '1;
        default: alpha_pick = ($urandom_range(0, 1) != 0) ? ALPHA_W'($urandom_range(1, 4096))
                                                          : ALPHA_W'($urandom_range(0, 131071));
      endcase
      corr_pick = (p < 4) ? (p != 2) : 1'($urandom_range(0, 1));
      write_reg(REG_ALPHA, alpha_pick);
      write_reg(REG_BIAS_CORR, {16'($urandom), corr_pick});
      for (int i = 0; i < per_phase; i++) begin
        if (i % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
        // occasional full drain before the next request
        if ($urandom_range(0, 99) == 0) wait_for_results();
        pick = $urandom_range(0, 39);
        case (pick)
          0:       value = DATA_MAX;
          1:       value = DATA_MIN;
          2, 3, 4: value = $urandom_range(0, 131071) - 65536;
          default: value = $urandom;
        endcase
        if ($urandom_range(0, 39) == 0) send_request(MODE_CLEAR, value);
        else send_request(MODE_SAMPLE, value);
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_SAMPLE;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    idle_on      = 1'b1;
    rx_wait      = 0;
    fail_count   = 0;
    results_seen = 0;
    alpha_q      = ALPHA_RESET;
    corr_on      = 1'b0;
    have_sample  = 1'b0;
    avg_q        = 0;
    bias_q       = BIAS_ONE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_saturation();
    test_alpha_limits();
    test_spare_index();
    test_random();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
